>>> rtl/entity_slot_allocator_store_assert.svh
// ----------------------------------------------------------------------------
// entity_slot_allocator_store assertion macros
// Shared property forms for the port checker, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef ENTITY_SLOT_ALLOCATOR_STORE_ASSERT_SVH
`define ENTITY_SLOT_ALLOCATOR_STORE_ASSERT_SVH

// same-cycle implication
`define ESAS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ESAS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/esas_pkg.sv
// ----------------------------------------------------------------------------
// esas_pkg
// Types and constants of the entity slot allocator store.
// ----------------------------------------------------------------------------
package esas_pkg;

    localparam int IDX_W       = 8;
    localparam int ELEM_W      = 32;
    localparam int VEC_W       = 3 * ELEM_W;
    localparam int IN_TDATA_W  = 112;
    localparam int OUT_TDATA_W = 112;

    localparam logic [ELEM_W-1:0] ONE_F_BITS = 32'h3F80_0000;

    typedef enum logic [1:0] {
        OP_CREATE = 2'd0,
        OP_FREE   = 2'd1,
        OP_READ   = 2'd2,
        OP_WRITE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_FULL     = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef logic [1:0] comp_t;

    localparam comp_t COMP_POSITION = 2'd0;
    localparam comp_t COMP_ROTATION = 2'd1;
    localparam comp_t COMP_SCALE    = 2'd2;

    typedef struct packed {
        status_t          status;
        logic             take_pop;
        logic [IDX_W-1:0] new_index;
        logic             read_ok;
        comp_t            comp;
    } result_ctl_t;

endpackage

>>> rtl/esas_ram.sv
// ----------------------------------------------------------------------------
// esas_ram
// Single-port-write, single-port-read table with registered read data.
// ----------------------------------------------------------------------------
module esas_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/entity_slot_allocator_store.sv
// ----------------------------------------------------------------------------
// entity_slot_allocator_store
// Entity slot table with a LIFO free list of released slots.
// ----------------------------------------------------------------------------
// One command word enters on the s_axis channel; one result word leaves on
// m_axis for every command. Create, free, read and write each take one pass.
// A command word is held in the input register, then table access fills the
// result register, from which the result is offered on m_axis.
// Throughput: one command per cycle while the receiver takes results, set by
// the single write port and single read port of each slot table and free list.
// The input register is released as soon as the result register is empty or
// being taken, so a new word is accepted while a finished result waits.
// When the receiver stalls, the result register holds, then the input
// register fills and s_axis_tready drops until m_axis_tready returns.
// Reset clears the high-water count and the free-list depth; the tables are
// not cleared and need no clearing pass, since every entry is written before
// it can be read. The block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module entity_slot_allocator_store #(
    parameter int MAX_ENTITIES = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // opcode, entity_index, component, value_x, value_y, value_z, zero pad
    input  logic [esas_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // status, new_index, read_x, read_y, read_z, zero pad
    output logic [esas_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    localparam int SLOT_W = (MAX_ENTITIES > 1) ? $clog2(MAX_ENTITIES) : 1;
    localparam int CNT_W  = $clog2(MAX_ENTITIES + 1);
    localparam int CMP_W  = (CNT_W > esas_pkg::IDX_W) ? CNT_W : esas_pkg::IDX_W;
    localparam int PAD_W  = esas_pkg::OUT_TDATA_W - esas_pkg::VEC_W - esas_pkg::IDX_W - 2;

    localparam logic [esas_pkg::VEC_W-1:0] ZERO_VEC  = '0;
    localparam logic [esas_pkg::VEC_W-1:0] SCALE_VEC =
        {esas_pkg::ONE_F_BITS, esas_pkg::ONE_F_BITS, esas_pkg::ONE_F_BITS};

    // input register
    logic                             in_valid_reg;
    esas_pkg::op_t                    in_op_reg;
    logic [esas_pkg::IDX_W-1:0]       in_index_reg;
    esas_pkg::comp_t                  in_comp_reg;
    logic [esas_pkg::VEC_W-1:0]       in_vec_reg;

    // result register
    logic                             out_valid_reg;
    esas_pkg::result_ctl_t            out_ctl_reg;
    esas_pkg::result_ctl_t            out_ctl_next;

    // allocator state
    logic [CNT_W-1:0]                 slots_used_reg;
    logic [CNT_W-1:0]                 slots_used_next;
    logic [CNT_W-1:0]                 free_top_reg;
    logic [CNT_W-1:0]                 free_top_next;

    logic                             accept;
    logic                             advance;
    logic                             index_ok;
    logic                             do_fresh;
    logic                             do_pop;
    logic                             do_push;
    logic                             do_write;

    logic [SLOT_W-1:0]                slot_addr;
    logic [SLOT_W-1:0]                fresh_addr;
    logic [SLOT_W-1:0]                pop_addr;
    logic [SLOT_W-1:0]                push_addr;
    logic [SLOT_W-1:0]                vec_waddr;
    logic [SLOT_W-1:0]                stack_rdata;

    logic                             pos_we;
    logic                             rot_we;
    logic                             scl_we;
    logic [esas_pkg::VEC_W-1:0]       pos_wdata;
    logic [esas_pkg::VEC_W-1:0]       rot_wdata;
    logic [esas_pkg::VEC_W-1:0]       scl_wdata;
    logic [esas_pkg::VEC_W-1:0]       pos_rdata;
    logic [esas_pkg::VEC_W-1:0]       rot_rdata;
    logic [esas_pkg::VEC_W-1:0]       scl_rdata;

    logic [esas_pkg::VEC_W-1:0]       read_vec;
    logic [esas_pkg::IDX_W-1:0]       new_index;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_op_reg    <= esas_pkg::op_t'(s_axis_tdata[1:0]);
            in_index_reg <= s_axis_tdata[9:2];
            in_comp_reg  <= s_axis_tdata[11:10];
            in_vec_reg   <= s_axis_tdata[107:12];
        end
    end

    assign index_ok   = CMP_W'(in_index_reg) < CMP_W'(slots_used_reg);
    assign slot_addr  = SLOT_W'(in_index_reg);
    assign fresh_addr = SLOT_W'(slots_used_reg);
    assign pop_addr   = SLOT_W'(free_top_reg - CNT_W'(1));
    assign push_addr  = SLOT_W'(free_top_reg);

    always_comb
    begin
        out_ctl_next.status    = esas_pkg::ST_OK;
        out_ctl_next.take_pop  = 1'b0;
        out_ctl_next.new_index = '0;
        out_ctl_next.read_ok   = 1'b0;
        out_ctl_next.comp      = in_comp_reg;
        do_fresh = 1'b0;
        do_pop   = 1'b0;
        do_push  = 1'b0;
        do_write = 1'b0;
        unique case (in_op_reg)
            esas_pkg::OP_CREATE:
            begin
                if (free_top_reg != '0)
                begin
                    do_pop = 1'b1;
                    out_ctl_next.take_pop = 1'b1;
                end
                else if (slots_used_reg == CNT_W'(MAX_ENTITIES))
                begin
                    out_ctl_next.status = esas_pkg::ST_FULL;
                end
                else
                begin
                    do_fresh = 1'b1;
                    out_ctl_next.new_index = esas_pkg::IDX_W'(slots_used_reg);
                end
            end
            esas_pkg::OP_FREE:
            begin
                if (!index_ok)
                begin
                    out_ctl_next.status = esas_pkg::ST_RANGE;
                end
                else if (free_top_reg == CNT_W'(MAX_ENTITIES))
                begin
                    out_ctl_next.status = esas_pkg::ST_OVERFLOW;
                end
                else
                begin
                    do_push = 1'b1;
                end
            end
            esas_pkg::OP_READ:
            begin
                if (!index_ok)
                begin
                    out_ctl_next.status = esas_pkg::ST_RANGE;
                end
                else
                begin
                    out_ctl_next.read_ok = 1'b1;
                end
            end
            esas_pkg::OP_WRITE:
            begin
                if (!index_ok)
                begin
                    out_ctl_next.status = esas_pkg::ST_RANGE;
                end
                else
                begin
                    do_write = 1'b1;
                end
            end
            default:
            begin
                out_ctl_next.status = esas_pkg::ST_OK;
            end
        endcase
    end

    always_comb
    begin
        slots_used_next = slots_used_reg;
        free_top_next   = free_top_reg;
        if (do_fresh)
        begin
            slots_used_next = slots_used_reg + CNT_W'(1);
        end
        if (do_pop)
        begin
            free_top_next = free_top_reg - CNT_W'(1);
        end
        else if (do_push)
        begin
            free_top_next = free_top_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            slots_used_reg <= '0;
            free_top_reg   <= '0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg  <= 1'b1;
                slots_used_reg <= slots_used_next;
                free_top_reg   <= free_top_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_ctl_reg <= out_ctl_next;
        end
    end

    // slot tables: defaults on fresh create and on free, data on write
    assign vec_waddr = do_fresh ? fresh_addr : slot_addr;
    assign pos_we    = advance && (do_fresh || do_push
                       || (do_write && in_comp_reg == esas_pkg::COMP_POSITION));
    assign rot_we    = advance && (do_fresh || do_push
                       || (do_write && in_comp_reg == esas_pkg::COMP_ROTATION));
    assign scl_we    = advance && (do_fresh || do_push
                       || (do_write && in_comp_reg == esas_pkg::COMP_SCALE));
    assign pos_wdata = do_write ? in_vec_reg : ZERO_VEC;
    assign rot_wdata = do_write ? in_vec_reg : ZERO_VEC;
    assign scl_wdata = do_write ? in_vec_reg : SCALE_VEC;

    esas_ram #(
        .WIDTH (esas_pkg::VEC_W),
        .DEPTH (MAX_ENTITIES)
    ) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (vec_waddr),
        .wdata (pos_wdata),
        .re    (advance),
        .raddr (slot_addr),
        .rdata (pos_rdata)
    );

    esas_ram #(
        .WIDTH (esas_pkg::VEC_W),
        .DEPTH (MAX_ENTITIES)
    ) u_rot_ram (
        .clk   (clk),
        .we    (rot_we),
        .waddr (vec_waddr),
        .wdata (rot_wdata),
        .re    (advance),
        .raddr (slot_addr),
        .rdata (rot_rdata)
    );

    esas_ram #(
        .WIDTH (esas_pkg::VEC_W),
        .DEPTH (MAX_ENTITIES)
    ) u_scl_ram (
        .clk   (clk),
        .we    (scl_we),
        .waddr (vec_waddr),
        .wdata (scl_wdata),
        .re    (advance),
        .raddr (slot_addr),
        .rdata (scl_rdata)
    );

    esas_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (MAX_ENTITIES)
    ) u_free_ram (
        .clk   (clk),
        .we    (advance && do_push),
        .waddr (push_addr),
        .wdata (slot_addr),
        .re    (advance),
        .raddr (pop_addr),
        .rdata (stack_rdata)
    );

    always_comb
    begin
        read_vec = ZERO_VEC;
        if (out_ctl_reg.read_ok)
        begin
            case (out_ctl_reg.comp)
                esas_pkg::COMP_POSITION: read_vec = pos_rdata;
                esas_pkg::COMP_ROTATION: read_vec = rot_rdata;
                esas_pkg::COMP_SCALE:    read_vec = scl_rdata;
                default:                 read_vec = ZERO_VEC;
            endcase
        end
    end

    assign new_index = out_ctl_reg.take_pop ? esas_pkg::IDX_W'(stack_rdata)
                                            : out_ctl_reg.new_index;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, read_vec, new_index, out_ctl_reg.status};

endmodule

>>> rtl/esas_checker.sv
// ----------------------------------------------------------------------------
// esas_checker
// Port-level checks of the entity slot allocator store, bound to the top.
// ----------------------------------------------------------------------------
`include "entity_slot_allocator_store_assert.svh"

module esas_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tready,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [esas_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    `ESAS_ASSERT_NXT(a_result_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result word changed while stalled")

    `ESAS_ASSERT_IMP(a_error_zero, m_axis_tvalid && (m_axis_tdata[1:0] != esas_pkg::ST_OK), m_axis_tdata[esas_pkg::OUT_TDATA_W-1:2] == '0, "error result carries data")

    `ESAS_ASSERT_IMP(a_ready_when_drained, !m_axis_tvalid, s_axis_tready, "input blocked with empty result register")

endmodule

bind entity_slot_allocator_store esas_checker u_esas_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> dv/entity_slot_allocator_store_test.sv
// ----------------------------------------------------------------------------
// entity_slot_allocator_store_test
// Self-checking bench for the entity slot table and its LIFO free list.
// ----------------------------------------------------------------------------
// A short table of directed commands walks the block from reset through
// create, read, write, free, double free and reuse. Random traffic follows in
// three stretches: a general mix, a fill run that drives the table to full,
// and a release run that drives the free list to overflow. Every command word
// is passed through a local slot table model and the result words are compared
// field by field, in order, against a typed row's reply, else the model's.
// ----------------------------------------------------------------------------
module entity_slot_allocator_store_test;

    localparam int MAX_SLOTS = 256;

    typedef struct packed {
        esas_pkg::op_t   op;
        logic [7:0]      idx;
        esas_pkg::comp_t comp;
        logic [31:0]     vx;
        logic [31:0]     vy;
        logic [31:0]     vz;
    } cmd_t;

    typedef struct packed {
        esas_pkg::status_t status;
        logic [7:0]        new_index;
        logic [31:0]       rd_x;
        logic [31:0]       rd_y;
        logic [31:0]       rd_z;
    } reply_t;

    typedef struct packed {
        cmd_t   cmd;
        logic   typed;
        reply_t want;
    } dir_row_t;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [esas_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [esas_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    int src_idle_pct  = 19;
    int sink_idle_pct = 85;
    int mismatches    = 0;

    // slot table model
    int                slots_used;
    int                free_depth;
    logic [7:0]        free_list [MAX_SLOTS];
    logic [2:0][31:0]  vec_store [3][MAX_SLOTS];

    reply_t   replies_due [$];
    dir_row_t plan [$];

    entity_slot_allocator_store #(.MAX_ENTITIES(MAX_SLOTS)) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [esas_pkg::IN_TDATA_W-1:0] pack_cmd(cmd_t c);
        return {4'b0, c.vz, c.vy, c.vx, c.comp, c.idx, c.op};
    endfunction

    function automatic void add_row(dir_row_t d);
        plan = {plan, d};
    endfunction

    function automatic void expect_reply(reply_t r);
        replies_due = {replies_due, r};
    endfunction

    function automatic void reset_slot(logic [7:0] s);
        vec_store[esas_pkg::COMP_POSITION][s] = '0;
        vec_store[esas_pkg::COMP_ROTATION][s] = '0;
        vec_store[esas_pkg::COMP_SCALE][s]    = {3{esas_pkg::ONE_F_BITS}};
    endfunction

    function automatic reply_t slot_table_apply(cmd_t c);
        reply_t r;
        r = '0;
        r.status = esas_pkg::ST_OK;
        if (c.op == esas_pkg::OP_CREATE)
        begin
            if (free_depth > 0)
            begin
                free_depth--;
                r.new_index = free_list[free_depth];
            end
            else if (slots_used >= MAX_SLOTS)
                r.status = esas_pkg::ST_FULL;
            else
            begin
                reset_slot(slots_used[7:0]);
                r.new_index = slots_used[7:0];
                slots_used++;
            end
        end
        else if (int'(c.idx) >= slots_used)
            r.status = esas_pkg::ST_RANGE;
        else if (c.op == esas_pkg::OP_FREE)
        begin
            if (free_depth >= MAX_SLOTS)
                r.status = esas_pkg::ST_OVERFLOW;
            else
            begin
                reset_slot(c.idx);
                free_list[free_depth] = c.idx;
                free_depth++;
            end
        end
        else if (c.comp <= esas_pkg::COMP_SCALE)
        begin
            if (c.op == esas_pkg::OP_READ)
            begin
                r.rd_x = vec_store[c.comp][c.idx][0];
                r.rd_y = vec_store[c.comp][c.idx][1];
                r.rd_z = vec_store[c.comp][c.idx][2];
            end
            else
                vec_store[c.comp][c.idx] = {c.vz, c.vy, c.vx};
        end
        return r;
    endfunction

    function automatic dir_row_t step_row(esas_pkg::op_t op, logic [7:0] idx,
                                          esas_pkg::comp_t comp,
                                          logic [31:0] val, logic typed = 1'b0,
                                          esas_pkg::status_t st = esas_pkg::ST_OK,
                                          logic [7:0] nidx = 8'd0,
                                          logic [31:0] rval = 32'd0);
        dir_row_t d;
        d.cmd  = '{op, idx, comp, val, ~val, {val[15:0], val[31:16]}};
        d.typed = typed;
        d.want = '{st, nidx, rval, rval, rval};
        return d;
    endfunction

    function automatic cmd_t random_cmd(int pct_create, int pct_free, int pct_read,
                                        int pct_inrange);
        cmd_t c;
        int   roll;
        roll = $urandom_range(99);
        if (roll < pct_create)
            c.op = esas_pkg::OP_CREATE;
        else if (roll < pct_create + pct_free)
            c.op = esas_pkg::OP_FREE;
        else if (roll < pct_create + pct_free + pct_read)
            c.op = esas_pkg::OP_READ;
        else
            c.op = esas_pkg::OP_WRITE;
        if (slots_used > 0 && $urandom_range(99) < pct_inrange)
            c.idx = 8'($urandom_range(slots_used - 1, 0));
        else if (slots_used < MAX_SLOTS)
            c.idx = 8'($urandom_range(MAX_SLOTS - 1, slots_used));
        else
            c.idx = 8'($urandom_range(255));
        c.comp = ($urandom_range(9) == 0) ? esas_pkg::comp_t'(2'd3)
                                          : esas_pkg::comp_t'($urandom_range(2));
        c.vx = $urandom;
        c.vy = $urandom;
        c.vz = $urandom;
        return c;
    endfunction

    task automatic issue_cmd(input cmd_t c, input logic typed, input reply_t want,
                             output reply_t got);
        if ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_cmd(c);
        do @(posedge clk); while (!s_axis_tready);
        got = slot_table_apply(c);
        expect_reply(typed ? want : got);
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] seen);
        if (want !== seen)
        begin
            $display("%0t %s expected %h actual %h", $time, what, want, seen);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : result_sink
        reply_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (replies_due.size() == 0)
            begin
                $display("%0t unexpected result word expected none actual %h",
                         $time, m_axis_tdata);
                mismatches++;
            end
            else
            begin
                want = replies_due.pop_front();
                check_field("status", 32'(want.status), 32'(m_axis_tdata[1:0]));
                check_field("new_index", 32'(want.new_index), 32'(m_axis_tdata[9:2]));
                check_field("read_x", want.rd_x, m_axis_tdata[41:10]);
                check_field("read_y", want.rd_y, m_axis_tdata[73:42]);
                check_field("read_z", want.rd_z, m_axis_tdata[105:74]);
            end
        end
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    initial
    begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        reply_t   got;
        int       full_hits;
        int       overflow_hits;

        full_hits     = 0;
        overflow_hits = 0;
        slots_used    = 0;
        free_depth    = 0;
        rst_n         = 1'b0;

        add_row(step_row(esas_pkg::OP_READ, 8'd0, esas_pkg::COMP_POSITION, 32'd0,
                         1'b1, esas_pkg::ST_RANGE));
        add_row(step_row(esas_pkg::OP_FREE, 8'd0, esas_pkg::COMP_POSITION, 32'd0,
                         1'b1, esas_pkg::ST_RANGE));
        add_row(step_row(esas_pkg::OP_WRITE, 8'd255, esas_pkg::COMP_SCALE, '1,
                         1'b1, esas_pkg::ST_RANGE));
        add_row(step_row(esas_pkg::OP_CREATE, 8'd255, esas_pkg::COMP_POSITION, 32'd0,
                         1'b1, esas_pkg::ST_OK, 8'd0));
        add_row(step_row(esas_pkg::OP_CREATE, 8'd0, esas_pkg::COMP_POSITION, 32'd0,
                         1'b1, esas_pkg::ST_OK, 8'd1));
        add_row(step_row(esas_pkg::OP_READ, 8'd0, esas_pkg::COMP_POSITION, 32'd0,
                         1'b1, esas_pkg::ST_OK));
        add_row(step_row(esas_pkg::OP_READ, 8'd0, esas_pkg::COMP_ROTATION, 32'd0,
                         1'b1, esas_pkg::ST_OK));
        add_row(step_row(esas_pkg::OP_READ, 8'd1, esas_pkg::COMP_SCALE, 32'd0,
                         1'b1, esas_pkg::ST_OK, 8'd0, esas_pkg::ONE_F_BITS));
        add_row(step_row(esas_pkg::OP_READ, 8'd2, esas_pkg::COMP_POSITION, 32'd0,
                         1'b1, esas_pkg::ST_RANGE));
        add_row(step_row(esas_pkg::OP_WRITE, 8'd1, esas_pkg::COMP_POSITION, '1,
                         1'b1, esas_pkg::ST_OK));
        add_row(step_row(esas_pkg::OP_READ, 8'd1, esas_pkg::COMP_POSITION, 32'd0));
        add_row(step_row(esas_pkg::OP_WRITE, 8'd1, esas_pkg::comp_t'(2'd3), 32'h1234_5678,
                         1'b1, esas_pkg::ST_OK));
        add_row(step_row(esas_pkg::OP_READ, 8'd1, esas_pkg::comp_t'(2'd3), 32'd0,
                         1'b1, esas_pkg::ST_OK));
        add_row(step_row(esas_pkg::OP_READ, 8'd1, esas_pkg::COMP_POSITION, 32'd0));
        add_row(step_row(esas_pkg::OP_WRITE, 8'd0, esas_pkg::COMP_SCALE, 32'h8000_0001,
                         1'b1, esas_pkg::ST_OK));
        add_row(step_row(esas_pkg::OP_READ, 8'd0, esas_pkg::COMP_SCALE, 32'd0));
        add_row(step_row(esas_pkg::OP_FREE, 8'd1, esas_pkg::COMP_POSITION, 32'd0,
                         1'b1, esas_pkg::ST_OK));
        add_row(step_row(esas_pkg::OP_READ, 8'd1, esas_pkg::COMP_POSITION, 32'd0,
                         1'b1, esas_pkg::ST_OK));
        add_row(step_row(esas_pkg::OP_FREE, 8'd0, esas_pkg::COMP_POSITION, 32'd0,
                         1'b1, esas_pkg::ST_OK));
        add_row(step_row(esas_pkg::OP_FREE, 8'd0, esas_pkg::COMP_POSITION, 32'd0,
                         1'b1, esas_pkg::ST_OK));
        add_row(step_row(esas_pkg::OP_CREATE, 8'd0, esas_pkg::COMP_POSITION, 32'd0,
                         1'b1, esas_pkg::ST_OK, 8'd0));
        add_row(step_row(esas_pkg::OP_CREATE, 8'd0, esas_pkg::COMP_POSITION, 32'd0,
                         1'b1, esas_pkg::ST_OK, 8'd0));
        add_row(step_row(esas_pkg::OP_CREATE, 8'd0, esas_pkg::COMP_POSITION, 32'd0,
                         1'b1, esas_pkg::ST_OK, 8'd1));
        add_row(step_row(esas_pkg::OP_CREATE, 8'd0, esas_pkg::COMP_POSITION, 32'd0,
                         1'b1, esas_pkg::ST_OK, 8'd2));
        add_row(step_row(esas_pkg::OP_READ, 8'd2, esas_pkg::COMP_SCALE, 32'd0,
                         1'b1, esas_pkg::ST_OK, 8'd0, esas_pkg::ONE_F_BITS));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
            issue_cmd(plan[i].cmd, plan[i].typed, plan[i].want, got);

        repeat (60)
            issue_cmd(random_cmd(35, 20, 25, 85), 1'b0, '0, got);

        // fill the table until create has reported full four times
        src_idle_pct  = 85;
        sink_idle_pct = 19;
        while (full_hits < 4)
        begin
            issue_cmd(random_cmd(90, 3, 4, 90), 1'b0, '0, got);
            if (got.status == esas_pkg::ST_FULL)
                full_hits++;
        end

        // release slots until the free list has overflowed four times
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        while (overflow_hits < 4)
        begin
            issue_cmd(random_cmd(0, 95, 3, 97), 1'b0, '0, got);
            if (got.status == esas_pkg::ST_OVERFLOW)
                overflow_hits++;
        end

        s_axis_tvalid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/esas_pkg.sv
rtl/esas_ram.sv
rtl/entity_slot_allocator_store.sv
rtl/esas_checker.sv
dv/entity_slot_allocator_store_test.sv
